@@ rtl/text_console_char_engine_defines.svh @@
// assertion macros for the text console character engine
`ifndef TEXT_CONSOLE_CHAR_ENGINE_DEFINES_SVH
`define TEXT_CONSOLE_CHAR_ENGINE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define TCCE_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("text console engine check failed");

// next-cycle implication, checked outside reset
`define TCCE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("text console engine check failed");

`endif

@@ rtl/tcce_pkg.sv @@
// shared types and constants of the text console character engine
package tcce_pkg;

    localparam int ACTION_W = 2;
    localparam int CHAR_W   = 8;
    localparam int COLOR_W  = 4;
    localparam int INDEX_W  = 11;
    localparam int COL_W    = 7;
    localparam int ROW_W    = 5;
    localparam int LOC_W    = 11;
    localparam int CELL_W   = 16;

    // blank cell: white on black space
    localparam logic [CELL_W-1:0] BLANK_CELL = 16'h0F20;

    localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_LAST  = 8'h7F;

    typedef enum logic [ACTION_W-1:0] {
        ACT_PUT   = 2'd0,
        ACT_CLEAR = 2'd1,
        ACT_READ  = 2'd2
    } t_action;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_EXEC,
        ST_SCROLL,
        ST_FLUSH,
        ST_BLANK,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic in_ready;
        logic put_exec;
        logic home;
        logic ptr_clr;
        logic blank_step;
        logic copy_step;
        logic read_issue;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic    in_valid;
        logic    out_free;
        t_action action;
        logic    put_scroll;
        logic    blank_last;
        logic    copy_last;
    } t_sts;

endpackage

@@ rtl/tcce_intf.sv @@
// transaction interfaces of the text console character engine
interface tcce_in_if;
    logic                           valid;
    logic                           ready;
    logic [tcce_pkg::ACTION_W-1:0]  action;
    logic [tcce_pkg::CHAR_W-1:0]    char_code;
    logic [tcce_pkg::COLOR_W-1:0]   bg_colour;
    logic [tcce_pkg::COLOR_W-1:0]   fg_colour;
    logic [tcce_pkg::INDEX_W-1:0]   cell_index;

    modport source (output valid, action, char_code, bg_colour, fg_colour, cell_index,
                    input ready);
    modport sink   (input valid, action, char_code, bg_colour, fg_colour, cell_index,
                    output ready);
endinterface

interface tcce_out_if;
    logic                          valid;
    logic                          ready;
    logic [tcce_pkg::COL_W-1:0]    cursor_col;
    logic [tcce_pkg::ROW_W-1:0]    cursor_row;
    logic [tcce_pkg::LOC_W-1:0]    cursor_location;
    logic [tcce_pkg::CELL_W-1:0]   cell_data;

    modport source (output valid, cursor_col, cursor_row, cursor_location, cell_data,
                    input ready);
    modport sink   (input valid, cursor_col, cursor_row, cursor_location, cell_data,
                    output ready);
endinterface

@@ rtl/tcce_ctrl.sv @@
// controller state machine of the text console character engine
module tcce_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  tcce_pkg::t_sts i_sts,
    output tcce_pkg::t_cmd o_cmd
);

    tcce_pkg::t_state r_state;
    tcce_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tcce_pkg::ST_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            tcce_pkg::ST_INIT: begin
                o_cmd.blank_step = 1'b1;
                if (i_sts.blank_last) begin
                    n_state = tcce_pkg::ST_IDLE;
                end
            end
            tcce_pkg::ST_IDLE: begin
                o_cmd.in_ready = 1'b1;
                if (i_sts.in_valid) begin
                    n_state = tcce_pkg::ST_EXEC;
                end
            end
            tcce_pkg::ST_EXEC: begin
                case (i_sts.action)
                    tcce_pkg::ACT_PUT: begin
                        o_cmd.put_exec = 1'b1;
                        if (i_sts.put_scroll) begin
                            o_cmd.ptr_clr = 1'b1;
                            n_state       = tcce_pkg::ST_SCROLL;
                        end else begin
                            n_state = tcce_pkg::ST_DONE;
                        end
                    end
                    tcce_pkg::ACT_CLEAR: begin
                        o_cmd.home    = 1'b1;
                        o_cmd.ptr_clr = 1'b1;
                        n_state       = tcce_pkg::ST_BLANK;
                    end
                    tcce_pkg::ACT_READ: begin
                        o_cmd.read_issue = 1'b1;
                        n_state          = tcce_pkg::ST_DONE;
                    end
                    default: begin
                        n_state = tcce_pkg::ST_DONE;
                    end
                endcase
            end
            tcce_pkg::ST_SCROLL: begin
                o_cmd.copy_step = 1'b1;
                if (i_sts.copy_last) begin
                    n_state = tcce_pkg::ST_FLUSH;
                end
            end
            tcce_pkg::ST_FLUSH: begin
                // last copied cell is written back this cycle
                n_state = tcce_pkg::ST_BLANK;
            end
            tcce_pkg::ST_BLANK: begin
                o_cmd.blank_step = 1'b1;
                if (i_sts.blank_last) begin
                    n_state = tcce_pkg::ST_DONE;
                end
            end
            tcce_pkg::ST_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = tcce_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = tcce_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

@@ rtl/tcce_dpath.sv @@
// datapath of the text console character engine: cursor, screen memory, result register
module tcce_dpath #(
    parameter int COLUMNS  = 80,
    parameter int ROWS     = 25,
    parameter int TAB_STOP = 8
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    tcce_in_if.sink        i_in,
    tcce_out_if.source     o_out,
    input  tcce_pkg::t_cmd i_cmd,
    output tcce_pkg::t_sts o_sts
);

    localparam int CELL_COUNT = COLUMNS * ROWS;
    localparam int AW = $clog2(CELL_COUNT);
    localparam int CW = $clog2(COLUMNS);
    localparam int RW = $clog2(ROWS);
    localparam int PW = $clog2(TAB_STOP);
    localparam int SW = $clog2(COLUMNS + TAB_STOP);

    logic [tcce_pkg::CELL_W-1:0] mem [CELL_COUNT];

    logic [CW-1:0] r_col;
    logic [RW-1:0] r_row;
    logic [PW-1:0] r_phase;
    logic [AW-1:0] r_ptr;
    logic [AW-1:0] r_wptr;
    logic          r_cp_pend;
    logic [tcce_pkg::CELL_W-1:0] r_rdata;
    logic          r_rd_ok;

    logic [tcce_pkg::ACTION_W-1:0] r_action;
    logic [tcce_pkg::CHAR_W-1:0]   r_char;
    logic [2*tcce_pkg::COLOR_W-1:0] r_attr;
    logic [tcce_pkg::INDEX_W-1:0]  r_index;

    logic                          r_out_valid;
    logic [tcce_pkg::COL_W-1:0]    r_out_col;
    logic [tcce_pkg::ROW_W-1:0]    r_out_row;
    logic [tcce_pkg::LOC_W-1:0]    r_out_loc;
    logic [tcce_pkg::CELL_W-1:0]   r_out_data;

    logic [SW-1:0] w_col_sum;
    logic [CW-1:0] w_col_nx;
    logic [RW-1:0] w_row_nx;
    logic [PW-1:0] w_phase_nx;
    logic          w_row_inc;
    logic          w_scroll;
    logic          w_wr_cell;
    logic [AW-1:0] w_loc;

    logic                        w_wr_en;
    logic [AW-1:0]               w_wr_addr;
    logic [tcce_pkg::CELL_W-1:0] w_wr_data;
    logic                        w_rd_en;
    logic [AW-1:0]               w_rd_addr;

    assign w_loc = AW'(r_row) * AW'(COLUMNS) + AW'(r_col);

    // put decode on the captured byte
    always_comb begin
        w_col_sum  = SW'(r_col);
        w_phase_nx = r_phase;
        w_row_inc  = 1'b0;
        w_wr_cell  = 1'b0;
        if (r_char == tcce_pkg::CH_BS && r_col != '0) begin
            w_col_sum  = SW'(r_col) - SW'(1);
            w_phase_nx = (r_phase == '0) ? PW'(TAB_STOP - 1) : r_phase - PW'(1);
        end else if (r_char == tcce_pkg::CH_TAB) begin
            w_col_sum  = SW'(r_col) + SW'(TAB_STOP) - SW'(r_phase);
            w_phase_nx = '0;
        end else if (r_char == tcce_pkg::CH_CR) begin
            w_col_sum  = '0;
            w_phase_nx = '0;
        end else if (r_char == tcce_pkg::CH_LF) begin
            w_col_sum  = '0;
            w_phase_nx = '0;
            w_row_inc  = 1'b1;
        end else if (r_char inside {[tcce_pkg::CH_SPACE:tcce_pkg::CH_LAST]}) begin
            w_wr_cell  = 1'b1;
            w_col_sum  = SW'(r_col) + SW'(1);
            w_phase_nx = (r_phase == PW'(TAB_STOP - 1)) ? '0 : r_phase + PW'(1);
        end

        if (w_col_sum >= SW'(COLUMNS)) begin
            w_col_nx   = '0;
            w_phase_nx = '0;
            w_row_inc  = 1'b1;
        end else begin
            w_col_nx = CW'(w_col_sum);
        end

        w_scroll = w_row_inc && (r_row == RW'(ROWS - 1));
        w_row_nx = (w_row_inc && !w_scroll) ? r_row + RW'(1) : r_row;
    end

    // single write port: pending copy, blanking, or character store
    always_comb begin
        w_wr_en   = 1'b0;
        w_wr_addr = r_ptr;
        w_wr_data = tcce_pkg::BLANK_CELL;
        if (r_cp_pend) begin
            w_wr_en   = 1'b1;
            w_wr_addr = r_wptr;
            w_wr_data = r_rdata;
        end else if (i_cmd.blank_step) begin
            w_wr_en = 1'b1;
        end else if (i_cmd.put_exec && w_wr_cell) begin
            w_wr_en   = 1'b1;
            w_wr_addr = w_loc;
            w_wr_data = {r_attr, r_char};
        end
    end

    assign w_rd_en   = i_cmd.copy_step || i_cmd.read_issue;
    assign w_rd_addr = i_cmd.copy_step ? r_ptr + AW'(COLUMNS) : AW'(r_index);

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            mem[w_wr_addr] <= w_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rd_en) begin
            r_rdata <= mem[w_rd_addr];
        end
    end

    // captured transaction
    always_ff @(posedge i_clk) begin
        if (i_cmd.in_ready && i_in.valid) begin
            r_action <= i_in.action;
            r_char   <= i_in.char_code;
            r_attr   <= {i_in.bg_colour, i_in.fg_colour};
            r_index  <= i_in.cell_index;
        end
        if (i_cmd.read_issue) begin
            r_rd_ok <= (32'(r_index) < CELL_COUNT);
        end
        r_wptr <= r_ptr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col       <= '0;
            r_row       <= '0;
            r_phase     <= '0;
            r_ptr       <= '0;
            r_cp_pend   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.put_exec) begin
                r_col   <= w_col_nx;
                r_row   <= w_row_nx;
                r_phase <= w_phase_nx;
            end else if (i_cmd.home) begin
                r_col   <= '0;
                r_row   <= '0;
                r_phase <= '0;
            end
            if (i_cmd.ptr_clr) begin
                r_ptr <= '0;
            end else if (i_cmd.blank_step || i_cmd.copy_step) begin
                r_ptr <= r_ptr + AW'(1);
            end
            r_cp_pend <= i_cmd.copy_step;
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_col  <= tcce_pkg::COL_W'(r_col);
            r_out_row  <= tcce_pkg::ROW_W'(r_row);
            r_out_loc  <= tcce_pkg::LOC_W'(w_loc);
            r_out_data <= (r_action == tcce_pkg::ACT_READ && r_rd_ok) ? r_rdata : '0;
        end
    end

    assign i_in.ready            = i_cmd.in_ready;
    assign o_out.valid           = r_out_valid;
    assign o_out.cursor_col      = r_out_col;
    assign o_out.cursor_row      = r_out_row;
    assign o_out.cursor_location = r_out_loc;
    assign o_out.cell_data       = r_out_data;

    assign o_sts.in_valid   = i_in.valid;
    assign o_sts.out_free   = !r_out_valid || o_out.ready;
    assign o_sts.action     = tcce_pkg::t_action'(r_action);
    assign o_sts.put_scroll = w_scroll;
    assign o_sts.blank_last = (r_ptr == AW'(CELL_COUNT - 1));
    assign o_sts.copy_last  = (r_ptr == AW'(CELL_COUNT - COLUMNS - 1));

endmodule

@@ rtl/text_console_char_engine.sv @@
// top level of the text console character engine
// Text console engine holding a COLUMNS x ROWS screen of 16-bit cells (character in the
// low byte, attribute in the high byte) and a cursor. Each input transaction is a put
// (control code or printable byte, stored with attribute bg_colour:fg_colour), a clear,
// or a read of one cell; every transaction returns exactly one result carrying the cursor,
// its linear location and, for a read, the cell. One transaction is worked at a time. A
// put or read is accepted, executed and has its result loaded. A put that runs off the
// bottom row scrolls: it copies COLUMNS*(ROWS-1) cells up a row, flushes the last copied
// cell and blanks the COLUMNS cells of the bottom row. A clear blanks all COLUMNS*ROWS
// cells. Both go through the screen memory's single write port, which moves one cell per
// cycle. After reset a clearing pass fills all COLUMNS*ROWS cells (2000 at 80x25) with
// blanks, during which no transaction is accepted. A finished result sits in an output
// register, so input is taken again while that result waits to be collected.
`include "text_console_char_engine_defines.svh"

module text_console_char_engine #(
    parameter int COLUMNS  = 80,
    parameter int ROWS     = 25,
    parameter int TAB_STOP = 8
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    tcce_in_if.sink    i_in,
    tcce_out_if.source o_out
);

    // command and status between sequencer and datapath
    tcce_pkg::t_cmd w_cmd;
    tcce_pkg::t_sts w_sts;

    tcce_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    tcce_dpath #(
        .COLUMNS  (COLUMNS),
        .ROWS     (ROWS),
        .TAB_STOP (TAB_STOP)
    ) u_dpath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .o_out   (o_out),
        .i_cmd   (w_cmd),
        .o_sts   (w_sts)
    );

    // at most one memory-touching operation per cycle
    `TCCE_ASSERT_SAME(a_one_mem_op, 1'b1, $onehot0({w_cmd.blank_step, w_cmd.copy_step, w_cmd.put_exec, w_cmd.read_issue}))
    // a result is only loaded when the output register is free
    `TCCE_ASSERT_SAME(a_out_load_free, w_cmd.out_load, w_sts.out_free)
    // one transaction in flight: no acceptance right after one
    `TCCE_ASSERT_NEXT(a_single_item, i_in.valid && i_in.ready, !i_in.ready)
    // reported column stays on screen
    `TCCE_ASSERT_SAME(a_col_range, o_out.valid, 32'(o_out.cursor_col) < COLUMNS)

endmodule

@@ bench/tb_text_console_char_engine.sv @@
`timescale 1ns / 1ps
// self-checking bench for the text console engine: queued stimulus, shadow screen, result checks
module tb_text_console_char_engine;

    // geometry of the engine under test (default parameters)
    localparam int COLUMNS  = 80;
    localparam int ROWS     = 25;
    localparam int TAB_STOP = 8;
    localparam int CELLS    = COLUMNS * ROWS;

    // stimulus sizing
    localparam int N_ITEMS     = 1450;  // transactions that do something, ignored bytes not counted
    localparam int CALM_TAIL   = 150;   // last transactions of the run, sent and taken with no idling
    localparam int HOLD_AFTER  = 400;   // transactions taken before the long output stall
    localparam int HOLD_CYCLES = 3000;  // length of that stall, longer than a scroll or a clear
    localparam int SETTLE      = 50;    // quiet cycles once nothing is outstanding

    // slowest run: every transaction a clear of all CELLS cells, plus gaps and stalls,
    // plus the clearing pass after reset, then several times over
    localparam int LIMIT_NS = 25_000_000;

    // action code with no meaning, sent to check that it leaves everything alone
    localparam logic [tcce_pkg::ACTION_W-1:0] ACT_SPARE = 2'd3;

    typedef struct {
        logic [tcce_pkg::ACTION_W-1:0] action;
        logic [tcce_pkg::CHAR_W-1:0]   char_code;
        logic [tcce_pkg::COLOR_W-1:0]  bg_colour;
        logic [tcce_pkg::COLOR_W-1:0]  fg_colour;
        logic [tcce_pkg::INDEX_W-1:0]  cell_index;
        bit                            wait_empty;  // sender pauses until every result is back
    } t_console_cmd;

    typedef struct {
        logic [tcce_pkg::COL_W-1:0]  col;
        logic [tcce_pkg::ROW_W-1:0]  row;
        logic [tcce_pkg::LOC_W-1:0]  loc;
        logic [tcce_pkg::CELL_W-1:0] data;
    } t_cursor_report;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    tcce_in_if  in_if ();
    tcce_out_if out_if ();

    text_console_char_engine u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // shadow of the engine: screen, cursor, and the step that updates them
    // ------------------------------------------------------------------
    logic [tcce_pkg::CELL_W-1:0] shadow_screen [CELLS];
    int unsigned                 shadow_col;
    int unsigned                 shadow_row;

    t_console_cmd   cmd_pending_q [$];   // transactions still to be offered
    t_cursor_report report_expect_q [$]; // results owed by the engine, oldest first
    t_console_cmd   cmd_on_bus;          // transaction currently offered

    int n_counted;     // stimulus that does something, for sizing only
    int total_items;
    int n_accepted;
    int n_results;
    int n_fail;
    int tx_gap;
    int rx_gap;

    function automatic void blank_cells(int unsigned from, int unsigned upto);
        for (int unsigned i = from; i < upto; i++)
            shadow_screen[i] = tcce_pkg::BLANK_CELL;
    endfunction

    function automatic bit is_printable(logic [tcce_pkg::CHAR_W-1:0] ch);
        return ch >= tcce_pkg::CH_SPACE && ch <= tcce_pkg::CH_LAST;
    endfunction

    // apply one transaction to the shadow state and return the result it owes
    function automatic t_cursor_report console_step(t_console_cmd c);
        t_cursor_report              r;
        logic [tcce_pkg::CELL_W-1:0] data;
        data = '0;
        if (c.action == tcce_pkg::ACT_PUT) begin
            if (c.char_code == tcce_pkg::CH_BS) begin
                // backspace stops at the left margin
                if (shadow_col != 0)
                    shadow_col--;
            end else if (c.char_code == tcce_pkg::CH_TAB) begin
                shadow_col = shadow_col - (shadow_col % TAB_STOP) + TAB_STOP;
            end else if (c.char_code == tcce_pkg::CH_CR) begin
                shadow_col = 0;
            end else if (c.char_code == tcce_pkg::CH_LF) begin
                shadow_col = 0;
                shadow_row++;
            end else if (is_printable(c.char_code)) begin
                shadow_screen[shadow_row * COLUMNS + shadow_col] =
                    {c.bg_colour, c.fg_colour, c.char_code};
                shadow_col++;
            end
            // wrap off the right edge, then scroll off the bottom
            if (shadow_col >= COLUMNS) begin
                shadow_col = 0;
                shadow_row++;
            end
            if (shadow_row >= ROWS) begin
                for (int unsigned i = 0; i < CELLS - COLUMNS; i++)
                    shadow_screen[i] = shadow_screen[i + COLUMNS];
                blank_cells(CELLS - COLUMNS, CELLS);
                shadow_row = ROWS - 1;
            end
        end else if (c.action == tcce_pkg::ACT_CLEAR) begin
            blank_cells(0, CELLS);
            shadow_col = 0;
            shadow_row = 0;
        end else if (c.action == tcce_pkg::ACT_READ) begin
            // out-of-range index reads as zero
            if (c.cell_index < CELLS)
                data = shadow_screen[c.cell_index];
        end
        r.col  = shadow_col[tcce_pkg::COL_W-1:0];
        r.row  = shadow_row[tcce_pkg::ROW_W-1:0];
        r.loc  = tcce_pkg::LOC_W'(shadow_row * COLUMNS + shadow_col);
        r.data = data;
        return r;
    endfunction

    function automatic void queue_cmd(logic [tcce_pkg::ACTION_W-1:0] act,
                                      logic [tcce_pkg::CHAR_W-1:0] ch,
                                      logic [tcce_pkg::COLOR_W-1:0] bg,
                                      logic [tcce_pkg::COLOR_W-1:0] fg,
                                      logic [tcce_pkg::INDEX_W-1:0] idx, bit hold = 1'b0);
        t_console_cmd c;
        c.action     = act;
        c.char_code  = ch;
        c.bg_colour  = bg;
        c.fg_colour  = fg;
        c.cell_index = idx;
        c.wait_empty = hold;
        cmd_pending_q.push_back(c);
        // bytes the engine drops do not count towards the stimulus size
        if (!(act == tcce_pkg::ACT_PUT && !is_printable(ch) && ch != tcce_pkg::CH_BS &&
              ch != tcce_pkg::CH_TAB && ch != tcce_pkg::CH_CR && ch != tcce_pkg::CH_LF))
            n_counted++;
    endfunction

    function automatic logic [tcce_pkg::INDEX_W-1:0] any_index();
        return tcce_pkg::INDEX_W'($urandom_range(0, (1 << tcce_pkg::INDEX_W) - 1));
    endfunction

    function automatic logic [tcce_pkg::COLOR_W-1:0] any_colour();
        return tcce_pkg::COLOR_W'($urandom_range(0, 15));
    endfunction

    function automatic logic [tcce_pkg::CHAR_W-1:0] any_byte();
        return tcce_pkg::CHAR_W'($urandom_range(0, 255));
    endfunction

    function automatic void check_field(string field, int unsigned want, int unsigned got);
        if (want != got) begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
            n_fail++;
        end
    endfunction

    // ------------------------------------------------------------------
    // stimulus: directed opening, then random sequences, then the end of run
    // ------------------------------------------------------------------
    initial begin
        int                           kind;
        int                           len;
        bit                           mid_hold_done;
        bit                           fixed_colour;
        logic [tcce_pkg::COLOR_W-1:0] bg;
        logic [tcce_pkg::COLOR_W-1:0] fg;
        logic [tcce_pkg::CHAR_W-1:0]  ch;

        // every input known from time zero
        in_if.valid      = 1'b0;
        in_if.action     = tcce_pkg::ACT_PUT;
        in_if.char_code  = '0;
        in_if.bg_colour  = '0;
        in_if.fg_colour  = '0;
        in_if.cell_index = '0;
        out_if.ready     = 1'b0;

        blank_cells(0, CELLS);
        shadow_col    = 0;
        shadow_row    = 0;
        mid_hold_done = 1'b0;

        // directed: colour extremes, backspace both ways, tabs, every action,
        // dropped bytes at both ends of the byte range, read indexes at and past the end
        queue_cmd(tcce_pkg::ACT_CLEAR, 8'h41, 4'h0, 4'h0, any_index());
        queue_cmd(tcce_pkg::ACT_PUT,   8'h41, 4'h0, 4'h0, any_index());
        queue_cmd(tcce_pkg::ACT_PUT,   tcce_pkg::CH_LAST, 4'hF, 4'hF, any_index());
        queue_cmd(tcce_pkg::ACT_PUT,   tcce_pkg::CH_SPACE, 4'hA, 4'h5, any_index());
        queue_cmd(tcce_pkg::ACT_READ,  8'h00, 4'h0, 4'h0, 11'd0);
        queue_cmd(tcce_pkg::ACT_READ,  8'hFF, 4'hF, 4'hF, 11'd1);
        queue_cmd(tcce_pkg::ACT_PUT,   tcce_pkg::CH_BS, 4'h0, 4'h0, any_index());
        queue_cmd(tcce_pkg::ACT_PUT,   8'h7A, 4'h5, 4'hA, any_index());
        queue_cmd(tcce_pkg::ACT_READ,  8'h00, 4'h0, 4'h0, 11'd2);
        queue_cmd(tcce_pkg::ACT_PUT,   tcce_pkg::CH_CR, 4'h0, 4'h0, any_index());
        queue_cmd(tcce_pkg::ACT_PUT,   tcce_pkg::CH_BS, 4'h0, 4'h0, any_index());
        queue_cmd(tcce_pkg::ACT_PUT,   tcce_pkg::CH_TAB, 4'h0, 4'h0, any_index());
        queue_cmd(tcce_pkg::ACT_PUT,   tcce_pkg::CH_TAB, 4'h0, 4'h0, any_index());
        queue_cmd(tcce_pkg::ACT_PUT,   tcce_pkg::CH_LF, 4'h0, 4'h0, any_index());
        queue_cmd(tcce_pkg::ACT_PUT,   8'h00, 4'hF, 4'hF, any_index());
        queue_cmd(tcce_pkg::ACT_PUT,   8'h1F, 4'hF, 4'hF, any_index());
        queue_cmd(tcce_pkg::ACT_PUT,   8'h80, 4'hF, 4'hF, any_index());
        queue_cmd(tcce_pkg::ACT_PUT,   8'hFF, 4'hF, 4'hF, any_index());
        queue_cmd(ACT_SPARE,           8'h41, 4'h3, 4'hC, any_index());
        queue_cmd(tcce_pkg::ACT_READ,  8'h00, 4'h0, 4'h0, 11'd1999);
        queue_cmd(tcce_pkg::ACT_READ,  8'h00, 4'h0, 4'h0, 11'd2000);
        queue_cmd(tcce_pkg::ACT_READ,  8'h00, 4'h0, 4'h0, 11'd2047);
        // sender waits for a drained engine before this clear
        queue_cmd(tcce_pkg::ACT_CLEAR, 8'h00, 4'h0, 4'h0, any_index(), 1'b1);
        queue_cmd(tcce_pkg::ACT_READ,  8'h00, 4'h0, 4'h0, 11'd0);

        // random part: mostly text, line feeds and reads so that wrap and scroll
        // happen often, with some noise and the odd clear
        while (n_counted < N_ITEMS) begin
            kind = $urandom_range(0, 99);
            if (kind < 40) begin
                // a run of printable text, one colour pair or colours per character
                len          = $urandom_range(5, 90);
                fixed_colour = 1'($urandom_range(0, 1));
                bg           = any_colour();
                fg           = any_colour();
                repeat (len) begin
                    if (!fixed_colour) begin
                        bg = any_colour();
                        fg = any_colour();
                    end
                    queue_cmd(tcce_pkg::ACT_PUT,
                              tcce_pkg::CHAR_W'($urandom_range(tcce_pkg::CH_SPACE,
                                                               tcce_pkg::CH_LAST)),
                              bg, fg, any_index());
                end
            end else if (kind < 55) begin
                // line feeds, enough at times to run off the bottom row
                len = $urandom_range(1, 27);
                repeat (len)
                    queue_cmd(tcce_pkg::ACT_PUT,
                              ($urandom_range(0, 5) == 0) ? tcce_pkg::CH_CR : tcce_pkg::CH_LF,
                              any_colour(), any_colour(), any_index());
            end else if (kind < 65) begin
                // cursor movement codes in any order
                len = $urandom_range(1, 10);
                repeat (len) begin
                    case ($urandom_range(0, 3))
                        0: ch = tcce_pkg::CH_BS;
                        1: ch = tcce_pkg::CH_TAB;
                        2: ch = tcce_pkg::CH_CR;
                        default: ch = tcce_pkg::CH_LF;
                    endcase
                    queue_cmd(tcce_pkg::ACT_PUT, ch, any_colour(), any_colour(), any_index());
                end
            end else if (kind < 80) begin
                // reads, mostly on screen
                len = $urandom_range(1, 8);
                repeat (len)
                    queue_cmd(tcce_pkg::ACT_READ, any_byte(), any_colour(), any_colour(),
                              ($urandom_range(0, 6) == 0)
                                  ? any_index()
                                  : tcce_pkg::INDEX_W'($urandom_range(0, CELLS - 1)));
            end else if (kind < 97) begin
                // noise: any action, any byte
                len = $urandom_range(1, 6);
                repeat (len)
                    queue_cmd(tcce_pkg::ACTION_W'($urandom_range(0, 3)), any_byte(),
                              any_colour(), any_colour(), any_index());
            end else begin
                queue_cmd(tcce_pkg::ACT_CLEAR, any_byte(), any_colour(), any_colour(),
                          any_index());
            end
            // once, half way: a read that waits until the engine has emptied
            if (!mid_hold_done && n_counted >= N_ITEMS / 2) begin
                queue_cmd(tcce_pkg::ACT_READ, 8'h00, 4'h0, 4'h0,
                          tcce_pkg::INDEX_W'($urandom_range(0, CELLS - 1)), 1'b1);
                mid_hold_done = 1'b1;
            end
        end
        total_items = cmd_pending_q.size();

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // everything offered and taken, then every result back, then a quiet spell
        while (cmd_pending_q.size() != 0 || in_if.valid)
            @(posedge i_clk);
        while (report_expect_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);

        if (n_fail == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial begin
        #(LIMIT_NS);
        $display("tb: failure");
        $finish;
    end

    // ------------------------------------------------------------------
    // input side: offers queued transactions, predicts each one taken
    // ------------------------------------------------------------------
    function automatic bit tx_idle_allowed();
        // alternate stretches with and without gaps, none near the end
        return cmd_pending_q.size() > CALM_TAIL && (n_accepted / 250) % 3 != 2;
    endfunction

    always @(posedge i_clk) begin
        bit taken;
        bit offer;
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
            tx_gap = 0;
        end else begin
            taken = in_if.valid && in_if.ready;
            if (taken) begin
                report_expect_q.push_back(console_step(cmd_on_bus));
                n_accepted++;
            end
            // an offered transaction stays on the bus until it is taken
            if (!(in_if.valid && !taken)) begin
                offer = 1'b0;
                if (tx_gap != 0) begin
                    tx_gap--;
                end else if (cmd_pending_q.size() != 0 &&
                             !(cmd_pending_q[0].wait_empty && report_expect_q.size() != 0)) begin
                    if (tx_idle_allowed() && $urandom_range(0, 7) == 0) begin
                        // idle gap that covers this cycle and tx_gap more
                        tx_gap = $urandom_range(0, 6);
                    end else begin
                        cmd_on_bus = cmd_pending_q.pop_front();
                        in_if.action     <= cmd_on_bus.action;
                        in_if.char_code  <= cmd_on_bus.char_code;
                        in_if.bg_colour  <= cmd_on_bus.bg_colour;
                        in_if.fg_colour  <= cmd_on_bus.fg_colour;
                        in_if.cell_index <= cmd_on_bus.cell_index;
                        offer = 1'b1;
                    end
                end
                in_if.valid <= offer;
            end
        end
    end

    // ------------------------------------------------------------------
    // long output stall, once, after a fixed number of transactions taken:
    // the engine's output register fills and it must stop taking input
    // ------------------------------------------------------------------
    int unsigned rx_hold_left;
    int unsigned rx_taken_seen;
    bit          rx_hold_done;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rx_hold_left  <= 0;
            rx_taken_seen <= 0;
            rx_hold_done  <= 1'b0;
        end else begin
            if (in_if.valid && in_if.ready)
                rx_taken_seen <= rx_taken_seen + 1;
            if (rx_hold_left != 0) begin
                rx_hold_left <= rx_hold_left - 1;
            end else if (!rx_hold_done && rx_taken_seen == HOLD_AFTER) begin
                rx_hold_left <= HOLD_CYCLES;
                rx_hold_done <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // output side: takes results with random stalls, checks each in order
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_cursor_report want;
        bit             take;
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
            rx_gap = 0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                if (report_expect_q.size() == 0) begin
                    $display({"%0t ns: result with none expected, expected nothing, ",
                              "actual col %0d row %0d data %0d"},
                             $time, out_if.cursor_col, out_if.cursor_row, out_if.cell_data);
                    n_fail++;
                end else begin
                    want = report_expect_q.pop_front();
                    check_field("cursor_col", 32'(want.col), 32'(out_if.cursor_col));
                    check_field("cursor_row", 32'(want.row), 32'(out_if.cursor_row));
                    check_field("cursor_location", 32'(want.loc),
                                32'(out_if.cursor_location));
                    check_field("cell_data", 32'(want.data), 32'(out_if.cell_data));
                end
                n_results++;
            end
            take = 1'b1;
            if (rx_hold_left != 0) begin
                take = 1'b0;
            end else if (rx_gap != 0) begin
                rx_gap--;
                take = 1'b0;
            end else if (n_results < total_items - CALM_TAIL && (n_results / 200) % 3 != 1 &&
                         $urandom_range(0, 7) == 0) begin
                rx_gap = $urandom_range(0, 6);
                take   = 1'b0;
            end
            out_if.ready <= take;
        end
    end

endmodule
